// ===== rtl/kps_pkg.sv =====
// kps_pkg: shared types and constants of the k-nearest point select unit
// no dependencies
package kps_pkg;

   localparam int MAX_POINTS = 64;
   localparam int MAX_PICK   = 16;

   localparam int PTR_W  = $clog2(MAX_POINTS);
   localparam int SCAN_W = $clog2(MAX_POINTS + 4);
   localparam int PICK_W = $clog2(MAX_PICK + 1);

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_KNN  = 2'd1;
   localparam logic [1:0] CMD_NN   = 2'd2;

   localparam logic REG_POINT_COUNT = 1'b0;

   // one table entry as held by a cell
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [15:0]        tag;
      logic               chosen;
   } entry_type;

   // query centre
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } centre_type;

   // cell controls from the sequencer
   typedef struct packed {
      logic shift;
      logic clear_chosen;
   } cell_ctl_type;

   // scored candidate leaving the distance pipe
   typedef struct packed {
      logic             valid;
      logic [PTR_W-1:0] idx;
      logic [15:0]      tag;
      logic [65:0]      score;
   } cand_type;

endpackage

// ===== rtl/kps_cell.sv =====
// kps_cell: one table slot of the rotating entry ring
// depends on kps_pkg
module kps_cell
   import kps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         load_en,
   input  entry_type    load_data,
   input  logic         set_chosen,
   input  entry_type    from_next,
   output entry_type    entry
);

   entry_type data_ff;
   logic      chosen_ff;
   logic      chosen_in;

   assign entry = '{x: data_ff.x, y: data_ff.y, z: data_ff.z, tag: data_ff.tag,
                    chosen: chosen_ff};

   // chosen bit follows the entry around the ring
   always_comb begin
      chosen_in = chosen_ff;
      priority if (ctl.shift) begin
         chosen_in = from_next.chosen;
      end else if (ctl.clear_chosen) begin
         chosen_in = 1'b0;
      end else if (set_chosen) begin
         chosen_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chosen_ff <= 1'b0;
      end else begin
         chosen_ff <= chosen_in;
      end
   end

   // payload: shift from neighbor or load
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         data_ff <= from_next;
      end else if (load_en) begin
         data_ff <= load_data;
      end
   end

endmodule

// ===== rtl/kps_dist.sv =====
// kps_dist: pipelined squared distance of the entry at the ring head
// depends on kps_pkg
module kps_dist
   import kps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             feed_valid,
   input  logic [PTR_W-1:0] feed_idx,
   input  entry_type        feed_entry,
   input  centre_type       query,
   output cand_type         cand
);

   logic             a_valid_ff, b_valid_ff;
   logic [PTR_W-1:0] a_idx_ff, b_idx_ff;
   logic [15:0]      a_tag_ff, b_tag_ff;
   logic [31:0]      ax_ff, ay_ff, az_ff;
   logic [63:0]      sx_ff, sy_ff, sz_ff;
   logic [31:0]      ax_in, ay_in, az_in;

   function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
      logic signed [32:0] d;
      logic [32:0]        m;
      d = {a[31], a} - {b[31], b};
      m = d[32] ? 33'(-d) : 33'(d);
      return m[31:0];
   endfunction

   assign ax_in = abs_diff(feed_entry.x, query.x);
   assign ay_in = abs_diff(feed_entry.y, query.y);
   assign az_in = abs_diff(feed_entry.z, query.z);

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= feed_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   // differences, then squares
   always_ff @(posedge clock) begin
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      az_ff    <= az_in;
      a_idx_ff <= feed_idx;
      a_tag_ff <= feed_entry.tag;
      sx_ff    <= 64'(ax_ff) * 64'(ax_ff);
      sy_ff    <= 64'(ay_ff) * 64'(ay_ff);
      sz_ff    <= 64'(az_ff) * 64'(az_ff);
      b_idx_ff <= a_idx_ff;
      b_tag_ff <= a_tag_ff;
   end

   // exact 66-bit sum
   assign cand.valid = b_valid_ff;
   assign cand.idx   = b_idx_ff;
   assign cand.tag   = b_tag_ff;
   assign cand.score = 66'(sx_ff) + 66'(sy_ff) + 66'(sz_ff);

endmodule

// ===== rtl/k_nearest_point_select_unit.sv =====
// k_nearest_point_select_unit: top level, ring of entry cells plus scan sequencer
// depends on kps_pkg, kps_cell, kps_dist
//
// Usage:
// Requests come on req_ (tuser = cmd). A load writes one slot and answers
// with one response in the next cycle. A k-nearest request gives want_count
// responses (saturated to 1..MAX_PICK), a nearest request gives one; the
// final response of a request carries rsp_tlast. rsp_tuser is the status
// bit: 1 means no candidate was left (index and tag are zero then).
// Each response of a query costs one full turn of the cell ring, then the
// distance pipeline drains and the response is issued, so a k-nearest
// request takes k such turns.
// The ring rotates one slot a cycle past a single distance unit at its head.
// One request is worked at a time; a new request is taken once the previous
// one has finished and its last response has left the output register.
// A stalled receiver holds the response register; the next scan still runs
// and the sequencer then waits at the issue step until the register frees.
// Reset clears the control state, the chosen bits and point_count; table
// contents stay undefined until loaded. point_count is set over csr_.
module k_nearest_point_select_unit
   import kps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: entry_index[5:0], pos_x[37:6], pos_y[69:38], pos_z[101:70],
   //        frame_tag[117:102], want_count[122:118], skip_same_tag[123], zero fill
   input  logic [127:0] req_tdata,
   // tuser: cmd[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: found_index[5:0], found_tag[21:6], zero fill
   output logic [23:0]  rsp_tdata,
   // tuser: status[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_type;

   state_type         state_ff;
   logic [6:0]        point_count_ff;
   logic [SCAN_W-1:0] scan_ff;
   logic [PTR_W-1:0]  head_idx_ff;
   logic [PICK_W-1:0] pick_ff, want_ff;
   logic              knn_ff, skip_ff;
   centre_type        query_ff;
   logic [15:0]       qtag_ff;
   logic              have_ff;
   logic [PTR_W-1:0]  best_idx_ff;
   logic [15:0]       best_tag_ff;
   logic [65:0]       best_dist_ff;
   logic              rsp_valid_ff, rsp_status_ff, rsp_last_ff;
   logic [5:0]        rsp_idx_ff;
   logic [15:0]       rsp_tag_ff;

   logic [5:0]        in_index;
   centre_type        in_centre;
   logic [15:0]       in_tag;
   logic [4:0]        in_want;
   logic              in_skip;
   logic              req_acc, out_free;
   logic [10:0]       active_n;
   logic [PICK_W-1:0] want_sat;
   logic              feed_valid;
   logic              load_hit;
   cell_ctl_type      ctl;
   entry_type         ring [MAX_POINTS];
   cand_type          cand;
   logic              take;

   // request fields
   assign in_index      = req_tdata[5:0];
   assign in_centre.x   = req_tdata[37:6];
   assign in_centre.y   = req_tdata[69:38];
   assign in_centre.z   = req_tdata[101:70];
   assign in_tag        = req_tdata[117:102];
   assign in_want       = req_tdata[122:118];
   assign in_skip       = req_tdata[123];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign load_hit   = req_acc && (req_tuser == CMD_LOAD)
                       && (11'(in_index) < 11'(MAX_POINTS));

   // saturate want_count to 1..MAX_PICK
   always_comb begin
      if (in_want == 5'd0) begin
         want_sat = PICK_W'(1);
      end else if (8'(in_want) > 8'(MAX_PICK)) begin
         want_sat = PICK_W'(MAX_PICK);
      end else begin
         want_sat = PICK_W'(in_want);
      end
   end

   assign active_n = (11'(point_count_ff) > 11'(MAX_POINTS)) ? 11'(MAX_POINTS)
                                                              : 11'(point_count_ff);

   // cell ring controls
   assign ctl.shift        = (state_ff == ST_SCAN) && (11'(scan_ff) < 11'(MAX_POINTS));
   assign ctl.clear_chosen = req_acc && (req_tuser == CMD_KNN);

   // candidate filter at ring head
   assign feed_valid = ctl.shift && (11'(head_idx_ff) < active_n)
                       && (!knn_ff || (!ring[0].chosen
                                       && !(skip_ff && ring[0].tag == qtag_ff)));

   genvar gi;
   generate
      for (gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
         kps_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .load_en    (load_hit && (in_index == 6'(gi))),
            .load_data  ('{x: in_centre.x, y: in_centre.y, z: in_centre.z,
                           tag: in_tag, chosen: 1'b0}),
            .set_chosen ((state_ff == ST_EMIT) && out_free && knn_ff && have_ff
                         && (best_idx_ff == PTR_W'(gi))),
            .from_next  (ring[(gi + 1) % MAX_POINTS]),
            .entry      (ring[gi])
         );
      end
   endgenerate

   kps_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .feed_valid (feed_valid),
      .feed_idx   (head_idx_ff),
      .feed_entry (ring[0]),
      .query      (query_ff),
      .cand       (cand)
   );

   // best candidate update, ties keep the earlier index
   assign take = cand.valid && (knn_ff || cand.score != 66'd0)
                 && (!have_ff || cand.score < best_dist_ff);

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= 7'd0;
         rsp_valid_ff   <= 1'b0;
         have_ff        <= 1'b0;
         scan_ff        <= '0;
         head_idx_ff    <= '0;
         pick_ff        <= '0;
         want_ff        <= '0;
         knn_ff         <= 1'b0;
         skip_ff        <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_POINT_COUNT) begin
            point_count_ff <= csr_pwdata[6:0];
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (take) begin
            have_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  unique case (req_tuser)
                     CMD_LOAD: begin
                        rsp_valid_ff <= 1'b1;
                     end
                     CMD_KNN, CMD_NN: begin
                        state_ff    <= ST_SCAN;
                        scan_ff     <= '0;
                        head_idx_ff <= '0;
                        pick_ff     <= '0;
                        want_ff     <= (req_tuser == CMD_KNN) ? want_sat : PICK_W'(1);
                        knn_ff      <= (req_tuser == CMD_KNN);
                        skip_ff     <= in_skip;
                        have_ff     <= 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               scan_ff <= scan_ff + SCAN_W'(1);
               if (ctl.shift) begin
                  head_idx_ff <= head_idx_ff + PTR_W'(1);
               end
               if (11'(scan_ff) == 11'(MAX_POINTS + 1)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (pick_ff + PICK_W'(1) == want_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff    <= ST_SCAN;
                     pick_ff     <= pick_ff + PICK_W'(1);
                     scan_ff     <= '0;
                     head_idx_ff <= '0;
                     have_ff     <= 1'b0;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         query_ff <= in_centre;
         qtag_ff  <= in_tag;
      end
      if (take) begin
         best_idx_ff  <= cand.idx;
         best_tag_ff  <= cand.tag;
         best_dist_ff <= cand.score;
      end
      if (state_ff == ST_IDLE && req_acc) begin
         rsp_idx_ff    <= in_index;
         rsp_tag_ff    <= in_tag;
         rsp_status_ff <= !load_hit;
         rsp_last_ff   <= 1'b1;
      end else if (state_ff == ST_EMIT && out_free) begin
         rsp_idx_ff    <= have_ff ? 6'(best_idx_ff) : 6'd0;
         rsp_tag_ff    <= have_ff ? best_tag_ff : 16'd0;
         rsp_status_ff <= !have_ff;
         rsp_last_ff   <= (pick_ff + PICK_W'(1) == want_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_tag_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // register readback
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_POINT_COUNT) ? {25'd0, point_count_ff} : 32'd0;

endmodule

// ===== test/k_nearest_point_select_unit_tb.sv =====
// k_nearest_point_select_unit_tb: self-checking bench for the k-nearest point select unit
// depends on kps_pkg and k_nearest_point_select_unit; predicts responses in a scoreboard class
`timescale 1ns / 1ps

module k_nearest_point_select_unit_tb;
   import kps_pkg::*;

   localparam logic ST_OK   = 1'b0;
   localparam logic ST_NONE = 1'b1;

   // command code without meaning: no response expected
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]         cmd;
      logic [5:0]         slot;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [15:0]        tag;
      logic [4:0]         want;
      logic               skip;
   } request_type;

   typedef struct {
      logic [5:0]  idx;
      logic [15:0] tag;
      logic        status;
      logic        last;
   } pick_type;

   // table model plus queue of expected picks
   class pick_scoreboard;
      logic signed [31:0] cx [MAX_POINTS];
      logic signed [31:0] cy [MAX_POINTS];
      logic signed [31:0] cz [MAX_POINTS];
      logic [15:0]        ctag [MAX_POINTS];
      bit                 loaded [MAX_POINTS];
      int unsigned        count;
      pick_type           pending [$];
      int                 errors;

      function new();
         count = 0;
         errors = 0;
         foreach (loaded[i]) loaded[i] = 0;
      endfunction

      // slots written contiguously from slot 0
      function int loaded_prefix();
         int n;
         n = 0;
         while (n < MAX_POINTS && loaded[n]) n++;
         return n;
      endfunction

      function logic [65:0] sq_dist(int i, request_type r);
         longint d [3];
         logic [65:0] m;
         logic [65:0] acc;
         d[0] = longint'(cx[i]) - longint'(r.x);
         d[1] = longint'(cy[i]) - longint'(r.y);
         d[2] = longint'(cz[i]) - longint'(r.z);
         acc = '0;
         for (int a = 0; a < 3; a++) begin
            m = 66'(d[a] < 0 ? -d[a] : d[a]);
            acc = acc + m * m;
         end
         return acc;
      endfunction

      function void push(logic [5:0] idx, logic [15:0] tag, logic st, logic lst);
         pick_type p;
         p.idx = idx;
         p.tag = tag;
         p.status = st;
         p.last = lst;
         pending.insert(pending.size(), p);
      endfunction

      function void note_request(request_type r);
         int n, k, best;
         bit have;
         bit chosen [MAX_POINTS];
         logic [65:0] d, bd;
         n = (count > MAX_POINTS) ? MAX_POINTS : count;
         case (r.cmd)
            CMD_LOAD: begin
               cx[r.slot] = r.x;
               cy[r.slot] = r.y;
               cz[r.slot] = r.z;
               ctag[r.slot] = r.tag;
               loaded[r.slot] = 1;
               push(r.slot, r.tag, ST_OK, 1'b1);
            end
            CMD_KNN: begin
               k = (r.want == 0) ? 1 : (r.want > MAX_PICK ? MAX_PICK : r.want);
               foreach (chosen[i]) chosen[i] = 0;
               for (int p = 0; p < k; p++) begin
                  have = 0;
                  best = 0;
                  bd = '0;
                  for (int i = 0; i < n; i++) begin
                     if (chosen[i] || (r.skip && ctag[i] == r.tag)) continue;
                     d = sq_dist(i, r);
                     if (!have || d < bd) begin
                        have = 1;
                        best = i;
                        bd = d;
                     end
                  end
                  if (have) begin
                     chosen[best] = 1;
                     push(6'(best), ctag[best], ST_OK, p == k - 1);
                  end else begin
                     push('0, '0, ST_NONE, p == k - 1);
                  end
               end
            end
            CMD_NN: begin
               have = 0;
               best = 0;
               bd = '0;
               for (int i = 0; i < n; i++) begin
                  d = sq_dist(i, r);
                  if (d == 0) continue;
                  if (!have || d < bd) begin
                     have = 1;
                     best = i;
                     bd = d;
                  end
               end
               if (have) push(6'(best), ctag[best], ST_OK, 1'b1);
               else push('0, '0, ST_NONE, 1'b1);
            end
            default: ;
         endcase
      endfunction

      function void check_response(pick_type a);
         pick_type e;
         if (pending.size() == 0) begin
            $error("unexpected response idx=%0d tag=%0h", a.idx, a.tag);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.idx !== e.idx) begin
            $error("found_index expected %0d actual %0d", e.idx, a.idx);
            errors++;
         end
         if (a.tag !== e.tag) begin
            $error("found_tag expected %0h actual %0h", e.tag, a.tag);
            errors++;
         end
         if (a.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, a.status);
            errors++;
         end
         if (a.last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, a.last);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [23:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_psel = 0;
   logic         csr_penable = 0;
   logic         csr_pwrite = 0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   pick_scoreboard sb = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_off = 0;

   k_nearest_point_select_unit i_dut (.*);

   always #5 clock = ~clock;

   // receiver: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // monitor: responses are checked before the request of the same edge is noted
   always @(posedge clock) begin
      pick_type a;
      request_type r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.idx = rsp_tdata[5:0];
         a.tag = rsp_tdata[21:6];
         a.status = rsp_tuser;
         a.last = rsp_tlast;
         sb.check_response(a);
      end
      if (!reset && req_tvalid && req_tready) begin
         r.cmd = req_tuser;
         r.slot = req_tdata[5:0];
         r.x = req_tdata[37:6];
         r.y = req_tdata[69:38];
         r.z = req_tdata[101:70];
         r.tag = req_tdata[117:102];
         r.want = req_tdata[122:118];
         r.skip = req_tdata[123];
         sb.note_request(r);
      end
   end

   task automatic send_request(request_type r);
      if ($urandom_range(0, 99) < idle_pct) begin
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= r.cmd;
      req_tdata <= {4'b0, r.skip, r.want, r.tag, r.z, r.y, r.x, r.slot};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_slot(int slot, logic signed [31:0] x, y, z, logic [15:0] tag);
      request_type r;
      r = '{CMD_LOAD, 6'(slot), x, y, z, tag, 5'd1, 1'b0};
      send_request(r);
   endtask

   task automatic query(logic [1:0] cmd, logic signed [31:0] x, y, z, logic [15:0] tag,
                        logic [4:0] want, logic skip);
      request_type r;
      r = '{cmd, 6'($urandom), x, y, z, tag, want, skip};
      send_request(r);
   endtask

   // drain outstanding picks, then let a silent scan finish
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // only counts covering loaded slots are used
   task automatic set_point_count(int unsigned v);
      int p;
      p = sb.loaded_prefix();
      if (p < MAX_POINTS && v > p) v = p;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'(4 * REG_POINT_COUNT);
      csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.count = v & 7'h7f;
   endtask

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2000)) - 1000);
         2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
      endcase
   endfunction

   function automatic logic [15:0] pick_tag();
      return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
   endfunction

   task automatic random_request();
      request_type r;
      int s, sel;
      sel = $urandom_range(0, 99);
      r.cmd = (sel < 25) ? CMD_LOAD : (sel < 65) ? CMD_KNN : (sel < 95) ? CMD_NN : CMD_UNUSED;
      r.slot = 6'($urandom);
      r.tag = pick_tag();
      r.skip = 1'($urandom_range(0, 1));
      r.want = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 5));
      if (r.cmd != CMD_LOAD && $urandom_range(0, 2) == 0) begin
         // query centred on a stored entry: ties and zero distance
         s = $urandom_range(0, MAX_POINTS - 1);
         r.x = sb.cx[s];
         r.y = sb.cy[s];
         r.z = sb.cz[s];
         if ($urandom_range(0, 1)) r.tag = sb.ctag[s];
      end else begin
         r.x = pick_coord();
         r.y = pick_coord();
         r.z = pick_coord();
      end
      send_request(r);
   endtask

   initial begin
      int idles [4] = '{0, 45, 0, 17};
      int stalls [4] = '{0, 0, 45, 17};
      int counts [4] = '{64, 100, 9, 127};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table: every query finds nothing
      query(CMD_KNN, 0, 0, 0, 0, 5'd0, 1'b0);
      query(CMD_KNN, 0, 0, 0, 0, 5'd31, 1'b1);
      query(CMD_NN, 32'sh7fffffff, 0, 0, 16'hffff, 5'd1, 1'b0);
      query(CMD_UNUSED, 0, 0, 0, 0, 5'd1, 1'b0);
      load_slot(0, 32'sh7fffffff, 32'sh80000000, 0, 16'hffff);
      load_slot(1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'h0000);
      load_slot(2, 0, 0, 0, 16'h0001);
      load_slot(3, 0, 0, 0, 16'h0001);
      load_slot(63, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 16'haaaa);
      settle();
      set_point_count(4);

      // saturation, tag skipping, ties and zero distance
      query(CMD_KNN, 0, 0, 0, 16'h0001, 5'd0, 1'b0);
      query(CMD_KNN, 0, 0, 0, 16'h0001, 5'd31, 1'b0);
      query(CMD_KNN, 0, 0, 0, 16'h0001, 5'd4, 1'b1);
      query(CMD_NN, 0, 0, 0, 16'h0000, 5'd1, 1'b0);
      query(CMD_KNN, 32'sh7fffffff, 32'sh80000000, 0, 16'hffff, 5'd16, 1'b1);
      query(CMD_NN, 32'sh7fffffff, 32'sh80000000, 0, 16'hffff, 5'd1, 1'b1);
      query(CMD_UNUSED, 32'sh7fffffff, 0, 0, 16'hffff, 5'd31, 1'b1);
      settle();

      // fill the whole table
      for (int s = 0; s < MAX_POINTS; s++)
         load_slot(s, pick_coord(), pick_coord(), pick_coord(), pick_tag());
      settle();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idles[ph];
         stall_pct = stalls[ph];
         set_point_count(counts[ph]);
         if (ph == 2) hold_off = 3000;
         repeat (10) random_request();
         settle();
      end
      set_point_count(0);
      query(CMD_KNN, 0, 0, 0, 0, 5'd3, 1'b0);
      settle();

      if (sb.errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
